@@ rtl/dcts_pkg.sv @@
package dcts_pkg;

  localparam int KEY_W    = 7;
  localparam int AMOUNT_W = 7;
  localparam int DATA_W   = 8;
  localparam int OP_W     = 2;
  localparam int REG_W    = 1;

  // Number of distinct key codes on the input.
  localparam int KEY_COUNT = 1 << KEY_W;

  // Largest table shape that the default voltages cover.
  localparam int MAX_VOICES = 5;
  localparam int MAX_PARAMS = 8;

  // Event codes.
  localparam logic [OP_W-1:0] OP_SCAN_RESET = 2'd0;
  localparam logic [OP_W-1:0] OP_SCAN_CLOCK = 2'd1;
  localparam logic [OP_W-1:0] OP_NOTE_ON    = 2'd2;
  localparam logic [OP_W-1:0] OP_CTRL_CHG   = 2'd3;

  // Configuration register indexes.
  localparam logic [REG_W-1:0] REG_PULSE_LENGTH = 1'b0;
  localparam logic [REG_W-1:0] REG_BASE_KEY     = 1'b1;

  localparam logic [DATA_W-1:0] PULSE_LENGTH_RST = 8'd57;
  localparam logic [KEY_W-1:0]  BASE_KEY_RST     = 7'd48;
  localparam logic [DATA_W-1:0] LEVEL_RST        = 8'd127;

  // Channel mask of the CV output.
  localparam logic [DATA_W-1:0] CV_CHANNEL = 8'd1;

  // Power-on voltages of the table, one row per voice.
  localparam logic [DATA_W-1:0] DEFAULT_CV [MAX_VOICES][MAX_PARAMS] = '{
    '{8'd128, 8'd96,  8'd128, 8'd128, 8'd128, 8'd128, 8'd64,  8'd128},
    '{8'd128, 8'd128, 8'd128, 8'd64,  8'd64,  8'd128, 8'd64,  8'd128},
    '{8'd196, 8'd128, 8'd255, 8'd128, 8'd64,  8'd128, 8'd128, 8'd128},
    '{8'd128, 8'd128, 8'd255, 8'd128, 8'd64,  8'd128, 8'd128, 8'd128},
    '{8'd64,  8'd128, 8'd255, 8'd128, 8'd64,  8'd128, 8'd128, 8'd128}
  };

endpackage

@@ rtl/dcts_if.sv @@
// Event channel into the scanner.
interface dcts_item_if;
  import dcts_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [KEY_W-1:0]    key;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, op, key, amount, input ready);
  modport sink   (input valid, op, key, amount, output ready);
endinterface

// DAC write channel out of the scanner.
interface dcts_dac_if;
  import dcts_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] dac_channels;
  logic [DATA_W-1:0] dac_value;
  logic              last;

  modport source (output valid, dac_channels, dac_value, last, input ready);
  modport sink   (input valid, dac_channels, dac_value, last, output ready);
endinterface

// Register write channel.
interface dcts_cfg_if;
  import dcts_pkg::*;

  logic              valid;
  logic              ready;
  logic [REG_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/drum_cv_trigger_scanner_top.sv @@
// Drum CV and trigger scanner. Events arrive on the item channel: scan reset,
// scan clock, note-on and control change. Each transfer of a scan clock gives
// one DAC write of the addressed table voltage to channel mask 1, followed by
// one trigger write (mask 8 shifted by the voice) for every voice whose
// trigger starts or has reached the pulse length; the final write of the
// group carries last. All other events change state only and give no write.
// An event is taken in every cycle while the hand-over stage is free, so
// non-scan events and scan clocks with short groups stream at one per cycle;
// a scan clock passes the hand-over stage and the output group register
// before its first write; its group of 1 to VOICES+1 writes goes out at one
// write per cycle while dac.ready is high, which sets the sustained scan rate.
// The voltage table lives in a single-port style RAM of VOICES*PARAMS_PER_VOICE
// bytes with a registered read; a valid flop per entry makes an entry that was
// never written read as its power-on default, so no clearing pass is needed.
// Registers may be written only while no event is in flight.
module drum_cv_trigger_scanner_top #(
  parameter int VOICES           = 5,
  parameter int PARAMS_PER_VOICE = 8
) (
  input logic        clk,
  input logic        rst,
  dcts_item_if.sink  item,
  dcts_dac_if.source dac,
  dcts_cfg_if.sink   cfg
);
  import dcts_pkg::*;

  localparam int TABLE_SIZE = VOICES * PARAMS_PER_VOICE;
  localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int SLOTS      = VOICES + 1;
  localparam int SLOT_W     = $clog2(SLOTS);
  // Highest key offset above base_key that still maps to a voice.
  localparam int MAX_OFFSET = 2 * VOICES - 2;

  typedef logic [ADDR_W-1:0] addr_lut_t [KEY_COUNT];
  typedef logic [DATA_W-1:0] def_lut_t [TABLE_SIZE];

  // Table address of a control change for every parameter number: the row is
  // the quotient clamped to the last voice, the column the remainder.
  function automatic addr_lut_t build_addr_lut();
    addr_lut_t lut;
    int        row;
    for (int k = 0; k < KEY_COUNT; k++) begin
      row = k / PARAMS_PER_VOICE;
      if (row > VOICES - 1) begin
        row = VOICES - 1;
      end
      lut[k] = ADDR_W'(row * PARAMS_PER_VOICE + k % PARAMS_PER_VOICE);
    end
    return lut;
  endfunction

  function automatic def_lut_t build_def_lut();
    def_lut_t lut;
    for (int r = 0; r < VOICES; r++) begin
      for (int c = 0; c < PARAMS_PER_VOICE; c++) begin
        lut[r * PARAMS_PER_VOICE + c] = DEFAULT_CV[r][c];
      end
    end
    return lut;
  endfunction

  localparam addr_lut_t ADDR_LUT = build_addr_lut();
  localparam def_lut_t  DEF_LUT  = build_def_lut();

  // Configuration.
  logic [DATA_W-1:0] pulse_length;
  logic [KEY_W-1:0]  base_key;

  // Scan and trigger state.
  logic [ADDR_W-1:0] scan_position;
  logic [DATA_W-1:0] trigger_count [VOICES];
  logic [DATA_W-1:0] trigger_level [VOICES];

  // Voltage table and its read port.
  logic [DATA_W-1:0] cv_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] cv_valid;
  logic [DATA_W-1:0] rd_mem;
  logic [DATA_W-1:0] rd_def;
  logic              rd_valid;

  // Hand-over stage: one scan clock whose table read is under way.
  logic              s1_valid;
  logic [VOICES-1:0] s1_emit;
  logic [DATA_W-1:0] s1_val [VOICES];

  // Output group: one value per slot and a mask of writes still to go.
  logic [DATA_W-1:0] ser_val [SLOTS];
  logic [SLOTS-1:0]  pend;

  logic              item_fire;
  logic              scan_fire;
  logic              note_fire;
  logic              cc_fire;
  logic              dac_fire;
  logic              pend_last;
  logic              load;
  logic [ADDR_W-1:0] cc_addr;
  logic [KEY_W-1:0]  key_offset;
  logic              key_hit;
  logic [VOICES-1:0] arm;
  logic [VOICES-1:0] trig_emit;
  logic [DATA_W-1:0] trig_val [VOICES];
  logic [SLOT_W-1:0] sel;

  assign item_fire = item.valid && item.ready;
  assign scan_fire = item_fire && (item.op == OP_SCAN_CLOCK);
  assign note_fire = item_fire && (item.op == OP_NOTE_ON);
  assign cc_fire   = item_fire && (item.op == OP_CTRL_CHG);
  assign dac_fire  = dac.valid && dac.ready;

  // The group is on its final write when a single bit of the mask is left.
  assign pend_last = (pend & (pend - SLOTS'(1))) == '0;
  // A waiting scan clock moves into the output group once the group is empty
  // or its final write is being taken.
  assign load       = s1_valid && ((pend == '0) || (dac_fire && pend_last));
  assign item.ready = !s1_valid || load;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_length <= PULSE_LENGTH_RST;
      base_key     <= BASE_KEY_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PULSE_LENGTH: pulse_length <= cfg.data;
        REG_BASE_KEY:     base_key     <= cfg.data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Note-on decode: two keys per voice from base_key, the last voice one key.
  assign key_offset = item.key - base_key;
  assign key_hit    = (item.key >= base_key) && (key_offset <= KEY_W'(MAX_OFFSET));

  always_comb begin
    for (int v = 0; v < VOICES; v++) begin
      arm[v] = note_fire && key_hit && (key_offset[KEY_W-1:1] == (KEY_W-1)'(v));
      // A trigger starts with its level on the first tick and returns to zero
      // from the pulse length onward; ticks in between give no write.
      trig_emit[v] = (trigger_count[v] != '0) &&
                     ((trigger_count[v] == DATA_W'(1)) ||
                      (trigger_count[v] >= pulse_length));
      trig_val[v]  = (trigger_count[v] == DATA_W'(1)) ? trigger_level[v] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < VOICES; v++) begin
        trigger_count[v] <= '0;
        trigger_level[v] <= LEVEL_RST;
      end
    end else begin
      for (int v = 0; v < VOICES; v++) begin
        if (arm[v]) begin
          trigger_count[v] <= DATA_W'(1);
          trigger_level[v] <= {item.amount, 1'b0};
        end else if (scan_fire && (trigger_count[v] != '0)) begin
          // Wraps past the top of the count, which leaves the voice idle.
          trigger_count[v] <= trigger_count[v] + DATA_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position <= '0;
    end else if (item_fire && (item.op == OP_SCAN_RESET)) begin
      scan_position <= '0;
    end else if (scan_fire) begin
      if (scan_position >= ADDR_W'(TABLE_SIZE - 1)) begin
        scan_position <= '0;
      end else begin
        scan_position <= scan_position + ADDR_W'(1);
      end
    end
  end

  // Control changes write the RAM; a scan clock reads it only in a later
  // transfer, so a read always sees every earlier write.
  assign cc_addr = ADDR_LUT[item.key];

  always_ff @(posedge clk) begin
    if (cc_fire) begin
      cv_mem[cc_addr] <= {item.amount, 1'b0};
    end
    if (scan_fire) begin
      rd_mem <= cv_mem[scan_position];
      rd_def <= DEF_LUT[scan_position];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_valid <= '0;
    end else if (cc_fire) begin
      cv_valid[cc_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_fire) begin
      rd_valid <= cv_valid[scan_position];
      s1_emit  <= trig_emit;
      for (int v = 0; v < VOICES; v++) begin
        s1_val[v] <= trig_val[v];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan_fire) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  // Output group. Slot 0 is the CV write, slot v+1 the trigger of voice v.
  always_ff @(posedge clk) begin
    if (load) begin
      ser_val[0] <= rd_valid ? rd_mem : rd_def;
      for (int v = 0; v < VOICES; v++) begin
        ser_val[v+1] <= s1_val[v];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load) begin
      pend <= {s1_emit, 1'b1};
    end else if (dac_fire) begin
      pend <= pend & (pend - SLOTS'(1));
    end
  end

  // Lowest pending slot goes out first.
  always_comb begin
    sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = SLOT_W'(i);
      end
    end
  end

  assign dac.valid        = pend != '0;
  assign dac.dac_value    = ser_val[sel];
  assign dac.dac_channels = (sel == '0) ? CV_CHANNEL
                                        : DATA_W'(DATA_W'(8) << (sel - SLOT_W'(1)));
  assign dac.last         = pend_last;

  // A scan clock is always followed by a group waiting in the hand-over stage.
  a_scan_to_stage: assert property (@(posedge clk) disable iff (rst)
    scan_fire |=> s1_valid)
    else $error("scan clock transfer did not reach the hand-over stage");

  // The scan position never leaves the table.
  a_position_range: assert property (@(posedge clk) disable iff (rst)
    scan_position <= ADDR_W'(TABLE_SIZE - 1))
    else $error("scan position beyond the table");

  // Every group opens with its CV write.
  a_group_opens_cv: assert property (@(posedge clk) disable iff (rst)
    load |=> pend[0])
    else $error("output group loaded without its CV write");

  // A stalled write keeps the rest of its group untouched.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    dac.valid && !dac.ready |=> $stable(pend))
    else $error("pending writes changed while the DAC channel stalled");

  // Nothing is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !dac.valid)
    else $error("DAC write offered right after reset");

endmodule

@@ bench/drum_cv_trigger_scanner_top_tb.sv @@
`timescale 1ns / 1ps

module drum_cv_trigger_scanner_top_tb;
  import dcts_pkg::*;

  localparam int VOICES           = 5;
  localparam int PARAMS_PER_VOICE = 8;
  localparam int TABLE_ENTRIES    = VOICES * PARAMS_PER_VOICE;
  // Keys base .. base + 2*VOICES-2 map onto voices, two keys per voice, the last voice one key.
  localparam int KEY_SPAN         = 2 * VOICES - 2;
  // Cycles allowed for the block to settle after the last DAC write.
  localparam int SETTLE_CYCLES    = 8;
  // Length of the deliberate receiver hold-off.
  localparam int HOLD_OFF_CYCLES  = 150;
  // Cycles without any transfer on any channel before the run is abandoned.
  localparam int QUIET_LIMIT      = 3000;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key;
    logic [AMOUNT_W-1:0] amount;
  } drum_event_t;

  typedef struct packed {
    logic [DATA_W-1:0] chans;
    logic [DATA_W-1:0] value;
    logic              last;
  } dac_write_t;

  logic clk;
  logic rst;

  dcts_item_if item_ch ();
  dcts_dac_if  dac_ch ();
  dcts_cfg_if  cfg_ch ();

  drum_cv_trigger_scanner_top #(
    .VOICES           (VOICES),
    .PARAMS_PER_VOICE (PARAMS_PER_VOICE)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .dac  (dac_ch),
    .cfg  (cfg_ch)
  );

  // Events waiting to be offered, and the DAC writes that the accepted events
  // are expected to produce, oldest first.
  drum_event_t event_backlog[$];
  dac_write_t  dac_writes_due[$];

  // Our own copy of the scanner state. The table, position and trigger state
  // are owned by the event driver; the two registers are owned by the
  // register writer in the main sequence, which only runs while idle.
  logic [DATA_W-1:0] cv_volts [TABLE_ENTRIES];
  logic [5:0]        scan_pos;
  logic [DATA_W-1:0] trig_count [VOICES];
  logic [DATA_W-1:0] trig_level [VOICES];
  logic [DATA_W-1:0] pulse_len;
  logic [KEY_W-1:0]  base_note;

  // Percentages of cycles in which the sender idles or the receiver stalls.
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  // Toggling hold_request asks the receiver process for one long hold-off.
  logic hold_request;
  logic hold_ack;
  int   hold_left;

  int faults;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the DAC writes that one accepted event causes and moves the
  // predicted state on. Scan clocks give the table voltage first and then
  // one write for each voice whose trigger is starting or has timed out.
  task automatic apply_event(input drum_event_t ev);
    dac_write_t  group[$];
    dac_write_t  w;
    int unsigned offset;
    int unsigned row;
    begin
      case (ev.op)
        OP_SCAN_RESET: begin
          scan_pos = '0;
        end
        OP_SCAN_CLOCK: begin
          w.chans = CV_CHANNEL;
          w.value = cv_volts[scan_pos];
          w.last  = 1'b0;
          group.push_back(w);
          scan_pos = (scan_pos == TABLE_ENTRIES - 1) ? '0 : scan_pos + 1'b1;
          for (int v = 0; v < VOICES; v++) begin
            if (trig_count[v] != 0) begin
              w.chans = DATA_W'(8 << v);
              if (trig_count[v] == 1) begin
                w.value = trig_level[v];
                group.push_back(w);
              end else if (trig_count[v] >= pulse_len) begin
                w.value = '0;
                group.push_back(w);
              end
              // An eight-bit counter: passing 255 leaves the voice idle.
              trig_count[v] = trig_count[v] + 1'b1;
            end
          end
          group[group.size() - 1].last = 1'b1;
          foreach (group[i]) dac_writes_due.push_back(group[i]);
        end
        OP_NOTE_ON: begin
          if (ev.key >= base_note) begin
            offset = ev.key - base_note;
            if (offset <= KEY_SPAN) begin
              trig_count[offset >> 1] = 8'd1;
              trig_level[offset >> 1] = {ev.amount, 1'b0};
            end
          end
        end
        default: begin
          // Control change: rows beyond the last voice land on the last voice.
          row = ev.key / PARAMS_PER_VOICE;
          if (row > VOICES - 1) row = VOICES - 1;
          cv_volts[row * PARAMS_PER_VOICE + ev.key % PARAMS_PER_VOICE] = {ev.amount, 1'b0};
        end
      endcase
    end
  endtask

  // Event driver. An offered event stays on the channel unchanged until its
  // transfer, and the next one is chosen in the same cycle as the transfer,
  // so each signal gets one assignment per edge.
  always @(posedge clk) begin : drive_events
    drum_event_t ev;
    if (rst) begin
      item_ch.valid <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        cv_volts[i] = DEFAULT_CV[i / PARAMS_PER_VOICE][i % PARAMS_PER_VOICE];
      end
      for (int v = 0; v < VOICES; v++) begin
        trig_count[v] = '0;
        trig_level[v] = LEVEL_RST;
      end
      scan_pos = '0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        ev.op     = item_ch.op;
        ev.key    = item_ch.key;
        ev.amount = item_ch.amount;
        apply_event(ev);
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (event_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          ev = event_backlog.pop_front();
          item_ch.valid  <= 1'b1;
          item_ch.op     <= ev.op;
          item_ch.key    <= ev.key;
          item_ch.amount <= ev.amount;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready. A toggle of hold_request starts a long hold-off, during
  // which the sender keeps offering so that the block backs up and stalls.
  always @(posedge clk) begin
    if (rst) begin
      dac_ch.ready <= 1'b0;
      hold_ack     <= 1'b0;
      hold_left    <= 0;
    end else if (hold_request != hold_ack) begin
      hold_ack     <= hold_request;
      hold_left    <= HOLD_OFF_CYCLES;
      dac_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      dac_ch.ready <= 1'b0;
    end else begin
      dac_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Each DAC write transfer is checked against the oldest expected write.
  always @(posedge clk) begin : check_dac
    dac_write_t got;
    dac_write_t want;
    if (rst) begin
      faults = 0;
    end else if (dac_ch.valid && dac_ch.ready) begin
      got.chans = dac_ch.dac_channels;
      got.value = dac_ch.dac_value;
      got.last  = dac_ch.last;
      if (dac_writes_due.size() == 0) begin
        $display("%0t: unexpected DAC write, expected none, got chans %0d value %0d last %0d",
                 $time, got.chans, got.value, got.last);
        faults++;
      end else begin
        want = dac_writes_due.pop_front();
        if (got !== want) begin
          $display({"%0t: DAC write mismatch, expected chans %0d value %0d last %0d,",
                    " got chans %0d value %0d last %0d"},
                   $time, want.chans, want.value, want.last,
                   got.chans, got.value, got.last);
          faults++;
        end
      end
    end
  end

  // Watchdog: the run is abandoned if no channel moves for too long.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (dac_ch.valid && dac_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_event(input logic [OP_W-1:0] op, input int unsigned key,
                             input int unsigned amount);
    drum_event_t ev;
    begin
      ev.op     = op;
      ev.key    = KEY_W'(key);
      ev.amount = AMOUNT_W'(amount);
      event_backlog.push_back(ev);
    end
  endtask

  // A random event. Note-ons mostly hit the mapped keys so that triggers do
  // fire; the rest of the keys still turn up as ignored notes.
  function automatic drum_event_t random_event(input int unsigned scan_pct,
                                               input int unsigned note_pct,
                                               input int unsigned ctrl_pct);
    drum_event_t ev;
    int unsigned roll;
    begin
      roll      = $urandom_range(99);
      ev.key    = KEY_W'($urandom_range(KEY_COUNT - 1));
      ev.amount = AMOUNT_W'($urandom_range(127));
      if (roll < scan_pct) begin
        ev.op = OP_SCAN_CLOCK;
      end else if (roll < scan_pct + note_pct) begin
        ev.op = OP_NOTE_ON;
        if ($urandom_range(3) != 0) ev.key = base_note + KEY_W'($urandom_range(KEY_SPAN));
      end else if (roll < scan_pct + note_pct + ctrl_pct) begin
        ev.op = OP_CTRL_CHG;
      end else begin
        ev.op = OP_SCAN_RESET;
      end
      return ev;
    end
  endfunction

  // Waits until every queued event has been taken and every expected write
  // has arrived, then lets the block settle, since events without writes may
  // still be in flight.
  task automatic wait_drained();
    begin
      do @(posedge clk);
      while (event_backlog.size() != 0 || item_ch.valid || dac_writes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  // Register write; only called while the scanner is idle.
  task automatic write_register(input logic [REG_W-1:0] index, input int unsigned value);
    begin
      @(posedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= index;
      cfg_ch.data  <= DATA_W'(value);
      do @(posedge clk);
      while (!cfg_ch.ready);
      cfg_ch.valid <= 1'b0;
      if (index == REG_PULSE_LENGTH) pulse_len = DATA_W'(value);
      else base_note = KEY_W'(value);
    end
  endtask

  task automatic run_random(input int count, input int unsigned scan_pct,
                            input int unsigned note_pct, input int unsigned ctrl_pct);
    begin
      repeat (count) event_backlog.push_back(random_event(scan_pct, note_pct, ctrl_pct));
      wait_drained();
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_PULSE_LENGTH;
    cfg_ch.data    = '0;
    pulse_len      = PULSE_LENGTH_RST;
    base_note      = BASE_KEY_RST;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_request   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed events with the registers at their reset values.
    queue_event(OP_SCAN_CLOCK, 0, 0);        // no trigger armed yet
    queue_event(OP_NOTE_ON, 48, 127);        // lowest mapped key, loudest
    queue_event(OP_NOTE_ON, 56, 0);          // highest mapped key, silent
    queue_event(OP_NOTE_ON, 57, 5);          // just above the mapped range
    queue_event(OP_NOTE_ON, 47, 5);          // just below it
    queue_event(OP_NOTE_ON, 50, 64);
    queue_event(OP_NOTE_ON, 53, 1);          // odd key shares the voice
    queue_event(OP_NOTE_ON, 54, 100);
    queue_event(OP_SCAN_CLOCK, 127, 127);    // every voice starts at once
    queue_event(OP_CTRL_CHG, 0, 127);
    queue_event(OP_CTRL_CHG, 127, 0);        // row clamped to the last voice
    queue_event(OP_CTRL_CHG, 39, 1);
    queue_event(OP_CTRL_CHG, 40, 85);        // first key past the table
    queue_event(OP_SCAN_CLOCK, 0, 0);
    queue_event(OP_SCAN_RESET, 127, 127);
    queue_event(OP_SCAN_CLOCK, 0, 0);        // reads the rewritten first entry
    queue_event(OP_SCAN_CLOCK, 0, 0);
    queue_event(OP_NOTE_ON, 127, 127);
    queue_event(OP_NOTE_ON, 0, 0);
    queue_event(OP_CTRL_CHG, 64, 42);
    queue_event(OP_SCAN_CLOCK, 0, 0);
    queue_event(OP_SCAN_RESET, 0, 0);
    wait_drained();

    // Shortest pulse and lowest base key, with no idling on either side.
    write_register(REG_PULSE_LENGTH, 1);
    write_register(REG_BASE_KEY, 0);
    run_random(25, 50, 30, 15);

    // Longest pulse and a high base key, with the sender often idle.
    write_register(REG_PULSE_LENGTH, 255);
    write_register(REG_BASE_KEY, 118);
    src_idle_pct = 58;
    run_random(25, 50, 30, 15);

    // The receiver stalls often and once holds off for a long stretch while
    // a scan-heavy burst keeps coming, so the block has to back up.
    write_register(REG_PULSE_LENGTH, $urandom_range(12, 2));
    write_register(REG_BASE_KEY, $urandom_range(118));
    src_idle_pct   = 0;
    sink_stall_pct = 58;
    hold_request   = ~hold_request;
    run_random(40, 80, 10, 5);

    // A long run of mostly scan clocks so that triggers time out. Every
    // voice is armed first. The idling pattern changes between chunks, and
    // each chunk drains before the next.
    write_register(REG_PULSE_LENGTH, $urandom_range(254, 2));
    write_register(REG_BASE_KEY, $urandom_range(118));
    for (int v = 0; v < VOICES; v++) begin
      queue_event(OP_NOTE_ON, base_note + 2 * v, $urandom_range(127));
    end
    for (int chunk = 0; chunk < 4; chunk++) begin
      src_idle_pct   = (chunk == 1) ? 58 : (chunk == 3) ? 14 : 0;
      sink_stall_pct = (chunk == 2) ? 58 : (chunk == 3) ? 14 : 0;
      run_random(40, 94, 2, 3);
    end

    // Any write that turns up now is one too many.
    repeat (20) @(posedge clk);
    if (dac_writes_due.size() != 0) begin
      $display("%0t: %0d expected DAC writes never arrived", $time, dac_writes_due.size());
    end
    if (faults == 0 && dac_writes_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/dcts_pkg.sv
rtl/dcts_if.sv
rtl/drum_cv_trigger_scanner_top.sv
bench/drum_cv_trigger_scanner_top_tb.sv
